// File: design/plto_pkg.sv
// Shared constants and types for the preemptive LIFO task order block.
package plto_pkg;

    // Stack depth and derived widths
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Field widths
    localparam int ID_W     = 10;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int DUR_W    = 7;
    localparam int TIME_W   = 11;
    localparam int LEFT_W   = 7;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 2;

    // Time constants
    localparam logic [TIME_W-1:0] END_MAX  = {TIME_W{1'b1}};
    localparam logic [LEFT_W-1:0] LEFT_MAX = {LEFT_W{1'b1}};

    // Stack control from the sequencer
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              upd;
        logic              clr;
        logic [ID_W-1:0]   id;
        logic [LEFT_W-1:0] left;
    } stk_ctrl_t;

endpackage

// File: design/plto_alu.sv
// Shared subtract and compare unit used by the task sequencer.
module plto_alu
    import plto_pkg::*;
(
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    output logic [TIME_W-1:0] diff,
    output logic              borrow,
    output logic              zero
);

    // Subtract with borrow out
    assign {borrow, diff} = {1'b0, a} - {1'b0, b};
    assign zero = (diff == '0);

endmodule

// File: design/plto_stack.sv
// Stack of preempted tasks: id and remaining minutes per entry.
module plto_stack
    import plto_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  stk_ctrl_t         ctrl,
    output logic [CNT_W-1:0]  count,
    output logic [ID_W-1:0]   top_id,
    output logic [LEFT_W-1:0] top_left
);

    logic [ID_W-1:0]   ids_reg  [STACK_DEPTH];
    logic [LEFT_W-1:0] left_reg [STACK_DEPTH];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [IDX_W-1:0]  top_idx;
    logic [IDX_W-1:0]  push_idx;
    logic [CNT_W-1:0]  cnt_dec;

    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign top_idx  = cnt_dec[IDX_W-1:0];
    assign push_idx = cnt_reg[IDX_W-1:0];

    // Track fill level
    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl.clr) begin
            cnt_next = '0;
        end else if (ctrl.push) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            cnt_next = cnt_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Write entries: push at the fill level, update remaining time at the top
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            ids_reg[push_idx]  <= ctrl.id;
            left_reg[push_idx] <= ctrl.left;
        end else if (ctrl.upd) begin
            left_reg[top_idx] <= ctrl.left;
        end
    end

    assign count    = cnt_reg;
    assign top_id   = ids_reg[top_idx];
    assign top_left = left_reg[top_idx];

endmodule

// File: design/preemptive_lifo_task_order.sv
// Top level of the preemptive LIFO task order block: sequencer and result buffer.
//
// Input channel s_*: one request per task, in start-time order. s_tdata holds
// task_id, start_hour, start_minute and duration; s_tlast marks the final task
// of a set. Result channel m_*: one item per finished task, in completion order.
// m_tdata holds done_id, m_tlast marks the last result caused by one request,
// m_tuser carries set_done and the sticky stack_overflow flag.
// A request passes through the compare, set-run and flush steps and emits its
// results in between; one that finds the running task done also checks the
// idle gap against the stack, with an update step when a stacked task is only
// partly worked off. The sequencer uses a single shared subtractor, one compare
// or pop per cycle unless an emit stalls; a request yields at most 34 results.
// s_tready is high only while the sequencer is idle. Results go through a
// one-deep hold stage and an output register; a stalled m_tready freezes the
// sequencer at its next emit and nothing is lost. The last result of a request
// leaves the hold stage once the sequencer knows no further result follows.
// Reset (aresetn low, synchronous) empties the stack, clears the running task
// and the overflow flag; no clearing pass is needed. After the final task of a
// set the block returns to that same state.
module preemptive_lifo_task_order
    import plto_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // task_id, start_hour, start_minute, duration
    input  logic                s_tlast,   // final_task
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // done_id
    output logic                m_tlast,   // last_of_run
    output logic [M_USER_W-1:0] m_tuser    // set_done, stack_overflow
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CMP    = 3'd1;
    localparam logic [2:0] ST_GAP    = 3'd2;
    localparam logic [2:0] ST_POP    = 3'd3;
    localparam logic [2:0] ST_TUPD   = 3'd4;
    localparam logic [2:0] ST_SETRUN = 3'd5;
    localparam logic [2:0] ST_DRAIN  = 3'd6;
    localparam logic [2:0] ST_FLUSH  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic              run_valid_reg, run_valid_next;
    logic [ID_W-1:0]   run_id_reg, run_id_next;
    logic [TIME_W-1:0] run_end_reg, run_end_next;
    logic              ovf_reg, ovf_next;
    logic [ID_W-1:0]   new_id_reg, new_id_next;
    logic [TIME_W-1:0] new_start_reg, new_start_next;
    logic [TIME_W-1:0] new_end_reg, new_end_next;
    logic              new_final_reg, new_final_next;
    logic [TIME_W-1:0] gap_reg, gap_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic              pend_ovf_reg, pend_ovf_next;
    logic              m_valid_reg, m_valid_next;
    logic [ID_W-1:0]   m_id_reg, m_id_next;
    logic              m_last_reg, m_last_next;
    logic              m_setd_reg, m_setd_next;
    logic              m_ovf_reg, m_ovf_next;

    logic [ID_W-1:0]   in_id;
    logic [HOUR_W-1:0] in_hour;
    logic [MIN_W-1:0]  in_min;
    logic [DUR_W-1:0]  in_dur;
    logic [TIME_W-1:0] in_start;
    logic [TIME_W:0]   in_end_sum;
    logic [TIME_W-1:0] in_end;

    logic [TIME_W-1:0] alu_a, alu_b, alu_diff;
    logic              alu_borrow, alu_zero;
    logic [LEFT_W-1:0] left_sat;

    stk_ctrl_t         stk;
    logic [CNT_W-1:0]  stk_count;
    logic [ID_W-1:0]   stk_top_id;
    logic [LEFT_W-1:0] stk_top_left;

    logic              out_free;
    logic              emit_ok;
    logic              emit_req;
    logic [ID_W-1:0]   emit_id;

    // Unpack the request and form start and saturated end time
    assign in_id      = s_tdata[ID_W-1:0];
    assign in_hour    = s_tdata[ID_W +: HOUR_W];
    assign in_min     = s_tdata[ID_W+HOUR_W +: MIN_W];
    assign in_dur     = s_tdata[ID_W+HOUR_W+MIN_W +: DUR_W];
    assign in_start   = ({{(TIME_W-HOUR_W){1'b0}}, in_hour} << 6)
                      - ({{(TIME_W-HOUR_W){1'b0}}, in_hour} << 2)
                      + {{(TIME_W-MIN_W){1'b0}}, in_min};
    assign in_end_sum = {1'b0, in_start} + {{(TIME_W+1-DUR_W){1'b0}}, in_dur};
    assign in_end     = in_end_sum[TIME_W] ? END_MAX : in_end_sum[TIME_W-1:0];

    // Operand select for the shared subtractor
    always_comb begin
        alu_a = run_end_reg;
        alu_b = new_start_reg;
        case (state_reg)
            ST_GAP: begin
                alu_a = new_start_reg;
                alu_b = run_end_reg;
            end
            ST_POP: begin
                alu_a = gap_reg;
                alu_b = {{(TIME_W-LEFT_W){1'b0}}, stk_top_left};
            end
            ST_TUPD: begin
                alu_a = {{(TIME_W-LEFT_W){1'b0}}, stk_top_left};
                alu_b = gap_reg;
            end
            default: begin
                alu_a = run_end_reg;
                alu_b = new_start_reg;
            end
        endcase
    end

    plto_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow),
        .zero   (alu_zero)
    );

    assign left_sat = (|alu_diff[TIME_W-1:LEFT_W]) ? LEFT_MAX : alu_diff[LEFT_W-1:0];

    plto_stack u_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (stk),
        .count    (stk_count),
        .top_id   (stk_top_id),
        .top_left (stk_top_left)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign emit_ok  = !pend_valid_reg || out_free;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        run_end_next   = run_end_reg;
        ovf_next       = ovf_reg;
        new_id_next    = new_id_reg;
        new_start_next = new_start_reg;
        new_end_next   = new_end_reg;
        new_final_next = new_final_reg;
        gap_next       = gap_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next   = pend_id_reg;
        pend_ovf_next  = pend_ovf_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_id_next      = m_id_reg;
        m_last_next    = m_last_reg;
        m_setd_next    = m_setd_reg;
        m_ovf_next     = m_ovf_reg;
        stk            = '0;
        emit_req       = 1'b0;
        emit_id        = run_id_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    new_id_next    = in_id;
                    new_start_next = in_start;
                    new_end_next   = in_end;
                    new_final_next = s_tlast;
                    state_next     = ST_CMP;
                end
            end
            ST_CMP: begin
                // Start directly if no task runs, else preempt the running task or go to the idle gap
                if (!run_valid_reg) begin
                    state_next = ST_SETRUN;
                end else if (!alu_borrow && !alu_zero) begin
                    if (stk_count < CNT_W'(STACK_DEPTH)) begin
                        stk.push = 1'b1;
                        stk.id   = run_id_reg;
                        stk.left = left_sat;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_SETRUN;
                end else begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP: begin
                // Emit the finished task and latch the idle gap
                emit_req = 1'b1;
                emit_id  = run_id_reg;
                if (emit_ok) begin
                    gap_next   = alu_diff;
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                // Spend the gap on stacked tasks, top first
                if (gap_reg == '0 || stk_count == '0) begin
                    state_next = ST_SETRUN;
                end else if (alu_borrow) begin
                    state_next = ST_TUPD;
                end else begin
                    emit_req = 1'b1;
                    emit_id  = stk_top_id;
                    if (emit_ok) begin
                        gap_next = alu_diff;
                        stk.pop  = 1'b1;
                    end
                end
            end
            ST_TUPD: begin
                stk.upd    = 1'b1;
                stk.left   = alu_diff[LEFT_W-1:0];
                gap_next   = '0;
                state_next = ST_SETRUN;
            end
            ST_SETRUN: begin
                run_valid_next = 1'b1;
                run_id_next    = new_id_reg;
                run_end_next   = new_end_reg;
                if (new_final_reg) begin
                    emit_req = 1'b1;
                    emit_id  = new_id_reg;
                    if (emit_ok) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_DRAIN: begin
                // Empty the whole stack at the end of a set
                if (stk_count == '0) begin
                    state_next = ST_FLUSH;
                end else begin
                    emit_req = 1'b1;
                    emit_id  = stk_top_id;
                    if (emit_ok) begin
                        stk.pop = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                // Release the held result as last of this request
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_id_next       = pend_id_reg;
                    m_ovf_next      = pend_ovf_reg;
                    m_last_next     = 1'b1;
                    m_setd_next     = new_final_reg;
                    pend_valid_next = 1'b0;
                    if (new_final_reg) begin
                        run_valid_next = 1'b0;
                        run_id_next    = '0;
                        run_end_next   = '0;
                        ovf_next       = 1'b0;
                        stk.clr        = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance the hold stage: older result moves out, new one is held
        if (emit_req && emit_ok) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_id_next    = pend_id_reg;
                m_ovf_next   = pend_ovf_reg;
                m_last_next  = 1'b0;
                m_setd_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = emit_id;
            pend_ovf_next   = ovf_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            run_valid_reg  <= 1'b0;
            run_id_reg     <= '0;
            run_end_reg    <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            run_valid_reg  <= run_valid_next;
            run_id_reg     <= run_id_next;
            run_end_reg    <= run_end_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        new_id_reg    <= new_id_next;
        new_start_reg <= new_start_next;
        new_end_reg   <= new_end_next;
        new_final_reg <= new_final_next;
        gap_reg       <= gap_next;
        pend_id_reg   <= pend_id_next;
        pend_ovf_reg  <= pend_ovf_next;
        m_id_reg      <= m_id_next;
        m_last_reg    <= m_last_next;
        m_setd_reg    <= m_setd_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-ID_W){1'b0}}, m_id_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_ovf_reg, m_setd_reg};

`ifndef SYNTH
    // No result may be held back while a new request is taken
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("held result while idle");

    // Stack never fills past its depth
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    // End of set is always the last result of its request
    a_setd_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("set_done without last_of_run");

    // After the final result leaves, the block is back at its reset state
    a_set_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && pend_valid_reg && out_free && new_final_reg)
        |=> (!run_valid_reg && stk_count == '0 && !ovf_reg))
        else $error("state not cleared after end of set");
`endif

endmodule

// File: tb/task_order_checker.sv
`timescale 1ns / 1ps
// Checker for the task order block: predicts the finished tasks and compares results.
module task_order_checker
    import plto_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // task_id, start_hour, start_minute, duration
    input  logic                s_tlast,   // final_task
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // done_id
    input  logic                m_tlast,   // last_of_run
    input  logic [M_USER_W-1:0] m_tuser,   // set_done, stack_overflow
    output int                  err_cnt,
    output int                  pending
);

    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOUR_LO = ID_W;
    localparam int MIN_LO  = ID_W + HOUR_W;
    localparam int DUR_LO  = ID_W + HOUR_W + MIN_W;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [DUR_W-1:0]  dur;
        logic              final_task;
    } task_req_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            last_of_run;
        logic            set_done;
        logic            overflow;
    } finished_t;

    // Finished tasks still owed by the block, oldest first
    finished_t         finished_q[$];

    // Shadow schedule: running task, paused stack, sticky overflow
    logic              run_valid;
    logic [ID_W-1:0]   run_id;
    logic [TIME_W-1:0] run_end;
    logic [ID_W-1:0]   paused_id   [STACK_DEPTH];
    logic [LEFT_W-1:0] paused_left [STACK_DEPTH];
    int                paused_cnt;
    logic              overflow_seen;
    int                errors = 0;

    function automatic void clear_schedule();
        run_valid     = 1'b0;
        run_id        = '0;
        run_end       = '0;
        paused_cnt    = 0;
        overflow_seen = 1'b0;
    endfunction

    function automatic void queue_finished(input logic [ID_W-1:0] id);
        finished_t f;
        f          = '0;
        f.id       = id;
        f.overflow = overflow_seen;
        finished_q.insert(finished_q.size(), f);
    endfunction

    // Advance the shadow schedule by one arriving task and queue what finishes
    function automatic void schedule_task(input task_req_t t);
        int unsigned start_t;
        int unsigned end_t;
        int unsigned gap;
        int unsigned left;
        int          n_before;
        finished_t   tail;
        n_before = finished_q.size();
        start_t  = t.hour * MINUTES_PER_HOUR + t.minute;
        end_t    = start_t + t.dur;
        if (end_t > END_MAX) end_t = END_MAX;

        if (run_valid) begin
            if (run_end > start_t) begin
                // preempt: park the running task with what it still needs
                left = run_end - start_t;
                if (left > LEFT_MAX) left = LEFT_MAX;
                if (paused_cnt < STACK_DEPTH) begin
                    paused_id[IDX_W'(paused_cnt)]   = run_id;
                    paused_left[IDX_W'(paused_cnt)] = LEFT_W'(left);
                    paused_cnt++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end else begin
                // running task done; spend the idle gap on the stack top down
                gap = start_t - run_end;
                queue_finished(run_id);
                while (gap > 0 && paused_cnt > 0) begin
                    if (paused_left[IDX_W'(paused_cnt-1)] > gap) begin
                        paused_left[IDX_W'(paused_cnt-1)] =
                            LEFT_W'(paused_left[IDX_W'(paused_cnt-1)] - gap);
                        gap = 0;
                    end else begin
                        gap = gap - paused_left[IDX_W'(paused_cnt-1)];
                        queue_finished(paused_id[IDX_W'(paused_cnt-1)]);
                        paused_cnt--;
                    end
                end
            end
        end

        run_valid = 1'b1;
        run_id    = t.id;
        run_end   = TIME_W'(end_t);

        // final task: emit it, then drain the whole stack
        if (t.final_task) begin
            queue_finished(run_id);
            while (paused_cnt > 0) begin
                paused_cnt--;
                queue_finished(paused_id[IDX_W'(paused_cnt)]);
            end
            clear_schedule();
        end

        // mark the last result of this request
        if (finished_q.size() > n_before) begin
            tail             = finished_q[finished_q.size()-1];
            tail.last_of_run = 1'b1;
            tail.set_done    = t.final_task;
            finished_q[finished_q.size()-1] = tail;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            errors++;
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, exp_v, got_v);
        end
    endfunction

    function automatic void check_result();
        finished_t want;
        if (finished_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, got id=%0d last=%b set=%b ovf=%b",
                     $time, m_tdata[ID_W-1:0], m_tlast, m_tuser[0], m_tuser[1]);
        end else begin
            want = finished_q[0];
            finished_q.delete(0);
            check_field("done_id", 32'(want.id), 32'(m_tdata[ID_W-1:0]));
            check_field("last_of_run", 32'(want.last_of_run), 32'(m_tlast));
            check_field("set_done", 32'(want.set_done), 32'(m_tuser[0]));
            check_field("stack_overflow", 32'(want.overflow), 32'(m_tuser[1]));
        end
    endfunction

    // Compare accepted results first, then predict from the accepted request
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_schedule();
            finished_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) begin
                schedule_task('{id:         s_tdata[ID_W-1:0],
                                hour:       s_tdata[HOUR_LO +: HOUR_W],
                                minute:     s_tdata[MIN_LO +: MIN_W],
                                dur:        s_tdata[DUR_LO +: DUR_W],
                                final_task: s_tlast});
            end
        end
        err_cnt <= errors;
        pending <= finished_q.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the task order testbench: clock, reset, request and result traffic, verdict.
module testbench;
    import plto_pkg::*;

    localparam int RANDOM_ITEMS = 230;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 60;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic [M_USER_W-1:0] m_tuser;

    int                  err_cnt;
    int                  pending;
    bit                  tx_steady  = 1'b0;
    logic                hold_go    = 1'b0;
    logic                hold_used  = 1'b0;
    int                  hold_left  = 0;
    int                  rx_cyc     = 0;
    int                  stall_cycles = 0;

    preemptive_lifo_task_order u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    task_order_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .err_cnt  (err_cnt),
        .pending  (pending)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Offer one task request and hold it until accepted
    task automatic send_task(input logic [ID_W-1:0] id, input logic [HOUR_W-1:0] hour,
                             input logic [MIN_W-1:0] minute, input logic [DUR_W-1:0] dur,
                             input logic fin);
        if (!tx_steady && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-ID_W-HOUR_W-MIN_W-DUR_W){1'b0}}, dur, minute, hour, id};
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Result side: random back-pressure, one long hold-off, one steady stretch
    always @(posedge aclk) begin
        rx_cyc <= rx_cyc + 1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (rx_cyc >= 800 && rx_cyc < 1600) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 13);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int sent;
        int set_len;
        int cursor;
        int k;
        bit dense;
        bit first_dense;
        bit fin;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // nothing running: first task just starts
        send_task(10'd0, 5'd0, 6'd0, 7'd1, 1'b0);
        // end equals start: running task finishes, stack untouched
        send_task(10'd1023, 5'd0, 6'd1, 7'd100, 1'b0);
        // preempt twice, one with the largest and one with zero duration
        send_task(10'd5, 5'd0, 6'd10, 7'd127, 1'b0);
        send_task(10'd6, 5'd0, 6'd20, 7'd0, 1'b0);
        // long gap pops the whole stack
        send_task(10'd7, 5'd23, 6'd59, 7'd50, 1'b0);
        // out-of-range time, end saturates
        send_task(10'd8, 5'd31, 6'd63, 7'd127, 1'b0);
        // start goes backwards: remaining time saturates
        send_task(10'd9, 5'd0, 6'd0, 7'd10, 1'b0);
        // final task drains the stack
        send_task(10'd10, 5'd0, 6'd5, 7'd10, 1'b1);
        // new set: partial work-off of a stacked task, then drain
        send_task(10'd100, 5'd1, 6'd0, 7'd30, 1'b0);
        send_task(10'd101, 5'd1, 6'd10, 7'd40, 1'b0);
        send_task(10'd102, 5'd1, 6'd15, 7'd5, 1'b0);
        send_task(10'd103, 5'd1, 6'd50, 7'd10, 1'b0);
        send_task(10'd104, 5'd2, 6'd10, 7'd1, 1'b1);
        // a set of a single final task
        send_task(10'd512, 5'd12, 6'd30, 7'd60, 1'b1);

        // random sets; the first one is dense enough to overflow the stack
        sent        = 0;
        first_dense = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            dense   = first_dense || ($urandom_range(0, 7) == 0);
            set_len = dense ? $urandom_range(34, 40) : $urandom_range(1, 12);
            if (set_len > RANDOM_ITEMS - sent) set_len = RANDOM_ITEMS - sent;
            cursor  = $urandom_range(0, 600);
            for (k = 0; k < set_len; k++) begin
                fin       = (k == set_len - 1);
                cursor    = cursor + (dense ? $urandom_range(0, 2) : $urandom_range(0, 60));
                if (cursor > 1439) cursor = 1439;
                tx_steady = (sent >= 80 && sent < 160);
                // hold off the results while the full stack drains
                if (first_dense && fin) hold_go <= 1'b1;
                if (!dense && $urandom_range(0, 9) == 0) begin
                    send_task(ID_W'($urandom_range(0, 1023)), HOUR_W'($urandom_range(0, 31)),
                              MIN_W'($urandom_range(0, 63)), DUR_W'($urandom_range(0, 127)),
                              fin);
                end else begin
                    send_task(ID_W'($urandom_range(0, 1023)), HOUR_W'(cursor / 60),
                              MIN_W'(cursor % 60),
                              DUR_W'(dense ? $urandom_range(60, 127) : $urandom_range(1, 100)),
                              fin);
                end
                sent++;
            end
            first_dense = 1'b0;
        end
        s_tvalid <= 1'b0;

        // drain outstanding results, then let the block settle
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
